// ----- rtl/sbcr_pkg.sv -----
// Shared types and constants for the spectrum bar column renderer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sbcr_pkg;

   localparam int MAX_DIM_DEFAULT = 64;

   // field widths fixed by the interface
   localparam int POS_W       = 6;
   localparam int ENERGY_W    = 16;
   localparam int COLOR_W     = 24;
   localparam int COUNT_W     = 7;
   localparam int LEVEL_W     = 8;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 2;

   // energy (Q8.8) times gain (Q4.4), height scale is a shift by 13
   localparam int ES_W         = ENERGY_W + LEVEL_W;
   localparam int HEIGHT_SHIFT = 13;

   // band split points in percent of the column count
   localparam int LOW_SPLIT  = 33;
   localparam int MID_SPLIT  = 66;
   localparam int PERCENT    = 100;
   localparam int HUE_SECTORS = 5;

   localparam logic [COUNT_W-1:0] ROWS_RESET  = 7'd16;
   localparam logic [COUNT_W-1:0] COLS_RESET  = 7'd16;
   localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 8'd255;
   localparam logic [LEVEL_W-1:0] SENS_RESET   = 8'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROW_COUNT    = 2'd0,
      REG_COLUMN_COUNT = 2'd1,
      REG_BRIGHTNESS   = 2'd2,
      REG_SENSITIVITY  = 2'd3
   } reg_index_type;

endpackage

`default_nettype wire

// ----- rtl/sbcr_csr.sv -----
// Configuration registers of the spectrum bar column renderer.
// Holds the four registers and clamps the matrix size to MAX_DIM. Uses sbcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbcr_csr #(
   parameter int MAX_DIM = sbcr_pkg::MAX_DIM_DEFAULT,
   parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [sbcr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sbcr_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic      [DIM_W-1:0]                    cfg_rows,
   output logic      [DIM_W-1:0]                    cfg_cols,
   output logic      [sbcr_pkg::LEVEL_W-1:0]        cfg_bright,
   output logic      [sbcr_pkg::LEVEL_W-1:0]        cfg_sens
);
   import sbcr_pkg::*;

   logic [COUNT_W-1:0] rows_ff, rows_in;
   logic [COUNT_W-1:0] cols_ff, cols_in;
   logic [LEVEL_W-1:0] bright_ff, bright_in;
   logic [LEVEL_W-1:0] sens_ff, sens_in;

   always_comb begin
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      bright_in = bright_ff;
      sens_in   = sens_ff;
      if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_ROW_COUNT:    rows_in   = csr_data[COUNT_W-1:0];
            REG_COLUMN_COUNT: cols_in   = csr_data[COUNT_W-1:0];
            REG_BRIGHTNESS:   bright_in = csr_data[LEVEL_W-1:0];
            REG_SENSITIVITY:  sens_in   = csr_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= ROWS_RESET;
         cols_ff   <= COLS_RESET;
         bright_ff <= BRIGHT_RESET;
         sens_ff   <= SENS_RESET;
      end else begin
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         bright_ff <= bright_in;
         sens_ff   <= sens_in;
      end
   end

   // oversized counts saturate at MAX_DIM
   assign cfg_rows   = (rows_ff > COUNT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(rows_ff);
   assign cfg_cols   = (cols_ff > COUNT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cols_ff);
   assign cfg_bright = bright_ff;
   assign cfg_sens   = sens_ff;

endmodule

`default_nettype wire

// ----- rtl/sbcr_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Shared by the hue sector and ramp computations. Uses sbcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbcr_div #(
   parameter int DIVD_W = 15,
   parameter int DIVS_W = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [DIVS_W-1:0] divisor,
   output logic                   done,
   output logic      [DIVD_W-1:0] quotient,
   output logic      [DIVS_W-1:0] remainder
);
   import sbcr_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dsr_ff, dsr_in;
   logic [DIVS_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits suffice
         rem_in = fits ? DIVS_W'(trial - {1'b0, dsr_ff}) : trial[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/spectrum_bar_column_renderer.sv -----
// Spectrum bar column renderer: one column of an LED-matrix bar graph per transfer.
// A request picks a band energy by column, turns it into a bar height and a rainbow
// color, then emits one pixel per row, top row first. An out-of-range column gives a
// single flagged empty pixel; a zero row count gives no pixels. A valid column first
// goes through setup, set by two passes through the one-bit-per-cycle shared divider
// (hue sector, then ramp), and then emits its pixels at one per cycle while the output
// side keeps up. DIVD_W = 8 + clog2(MAX_DIM+1). The next request is taken once the last
// pixel of a column is loaded into the output register.
// Depends on sbcr_pkg, sbcr_csr and sbcr_div.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_bar_column_renderer #(
   parameter int MAX_DIM = sbcr_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [sbcr_pkg::POS_W-1:0]          req_column,
   input  wire logic [sbcr_pkg::ENERGY_W-1:0]       req_low_band,
   input  wire logic [sbcr_pkg::ENERGY_W-1:0]       req_mid_band,
   input  wire logic [sbcr_pkg::ENERGY_W-1:0]       req_high_band,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [sbcr_pkg::COLOR_W-1:0]        rsp_pixel_color,
   output logic      [sbcr_pkg::POS_W-1:0]          rsp_row,
   output logic      [sbcr_pkg::POS_W-1:0]          rsp_col,
   output logic                                     rsp_last,
   output logic                                     rsp_bad_column,
   input  wire logic                                csr_write,
   input  wire logic [sbcr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sbcr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sbcr_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int DIVD_W = LEVEL_W + DIM_W;
   localparam int XC_W   = (DIM_W > POS_W) ? DIM_W : POS_W;
   localparam int BAND_W = XC_W + 7;
   localparam int PROD_W = ES_W + DIM_W;
   localparam int HQ_W   = PROD_W - HEIGHT_SHIFT;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BAD,
      ST_MUL1,
      ST_MUL2,
      ST_DIV1,
      ST_RAMP,
      ST_DIV2,
      ST_EMIT
   } state_type;

   logic [DIM_W-1:0]   cfg_rows, cfg_cols;
   logic [LEVEL_W-1:0] cfg_bright, cfg_sens;

   sbcr_csr #(
      .MAX_DIM (MAX_DIM),
      .DIM_W   (DIM_W)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg_rows   (cfg_rows),
      .cfg_cols   (cfg_cols),
      .cfg_bright (cfg_bright),
      .cfg_sens   (cfg_sens)
   );

   // divider control
   logic              div_start;
   logic [DIVD_W-1:0] div_dividend;
   logic              div_done;
   logic [DIVD_W-1:0] div_quotient;
   logic [DIM_W-1:0]  div_remainder;

   sbcr_div #(
      .DIVD_W (DIVD_W),
      .DIVS_W (DIM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cfg_cols),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   x_ff, x_in;
   logic [ENERGY_W-1:0] low_ff, low_in, mid_ff, mid_in, high_ff, high_in;
   logic [ENERGY_W-1:0] e_ff, e_in;
   logic [ES_W-1:0]    es_ff, es_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIM_W-1:0]   h_ff, h_in;
   logic [2:0]         k_ff, k_in;
   logic [DIM_W-1:0]   r_ff, r_in;
   logic [LEVEL_W-1:0] ramp_ff, ramp_in;
   logic [DIM_W-1:0]   y_ff, y_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic [POS_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [POS_W-1:0]    rsp_col_ff, rsp_col_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_bad_ff, rsp_bad_in;

   logic                req_xfer, out_free;
   logic [XC_W-1:0]     x_ext, c_ext;
   logic [BAND_W-1:0]   x_pct, low_lim, mid_lim;
   logic [HQ_W-1:0]     h_raw;
   logic [DIM_W-1:0]    ramp_arg;
   logic [LEVEL_W-1:0]  red, grn, blu;
   logic                lit;

   assign req_xfer = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign x_ext   = XC_W'(x_ff);
   assign c_ext   = XC_W'(cfg_cols);
   assign x_pct   = BAND_W'(x_ext) * BAND_W'(PERCENT);
   assign low_lim = BAND_W'(c_ext) * BAND_W'(LOW_SPLIT);
   assign mid_lim = BAND_W'(c_ext) * BAND_W'(MID_SPLIT);

   assign h_raw = prod_ff[PROD_W-1:HEIGHT_SHIFT];

   // odd sectors ramp down, even sectors ramp up
   assign ramp_arg = k_ff[0] ? (cfg_cols - r_ff) : r_ff;

   assign div_start    = (state_ff == ST_MUL1) || (state_ff == ST_RAMP);
   assign div_dividend = (state_ff == ST_MUL1)
                       ? DIVD_W'(x_ff) * DIVD_W'(HUE_SECTORS)
                       : DIVD_W'(cfg_bright) * DIVD_W'(ramp_arg);

   always_comb begin
      red = cfg_bright;
      grn = '0;
      blu = ramp_ff;
      case (k_ff)
         3'd0: begin red = cfg_bright; grn = ramp_ff;    blu = '0;         end
         3'd1: begin red = ramp_ff;    grn = cfg_bright; blu = '0;         end
         3'd2: begin red = '0;         grn = cfg_bright; blu = ramp_ff;    end
         3'd3: begin red = '0;         grn = ramp_ff;    blu = cfg_bright; end
         3'd4: begin red = ramp_ff;    grn = '0;         blu = cfg_bright; end
         default: begin red = cfg_bright; grn = '0;      blu = ramp_ff;    end
      endcase
   end

   assign lit = ({1'b0, y_ff} + {1'b0, h_ff}) >= {1'b0, cfg_rows};

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      low_in   = low_ff;
      mid_in   = mid_ff;
      high_in  = high_ff;
      e_in     = e_ff;
      es_in    = es_ff;
      prod_in  = prod_ff;
      h_in     = h_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      ramp_in  = ramp_ff;
      y_in     = y_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_color_in = rsp_color_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               x_in     = req_column;
               low_in   = req_low_band;
               mid_in   = req_mid_band;
               high_in  = req_high_band;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (x_ext >= c_ext) begin
               state_in = ST_BAD;
            end else if (cfg_rows == '0) begin
               state_in = ST_IDLE;
            end else begin
               if (x_pct < low_lim) begin
                  e_in = low_ff;
               end else if (x_pct < mid_lim) begin
                  e_in = mid_ff;
               end else begin
                  e_in = high_ff;
               end
               state_in = ST_MUL1;
            end
         end
         ST_BAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = '0;
               rsp_row_in   = '0;
               rsp_col_in   = x_ff;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MUL1: begin
            es_in    = ES_W'(e_ff) * ES_W'(cfg_sens);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in  = PROD_W'(es_ff) * PROD_W'(cfg_rows);
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            h_in = (h_raw > HQ_W'(cfg_rows)) ? cfg_rows : DIM_W'(h_raw);
            if (div_done) begin
               k_in     = div_quotient[2:0];
               r_in     = div_remainder;
               state_in = ST_RAMP;
            end
         end
         ST_RAMP: begin
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_done) begin
               ramp_in  = div_quotient[LEVEL_W-1:0];
               y_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = lit ? {red, grn, blu} : '0;
               rsp_row_in   = POS_W'(y_ff);
               rsp_col_in   = x_ff;
               rsp_last_in  = (y_ff + DIM_W'(1)) == cfg_rows;
               rsp_bad_in   = 1'b0;
               y_in         = y_ff + DIM_W'(1);
               if ((y_ff + DIM_W'(1)) == cfg_rows) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      low_ff       <= low_in;
      mid_ff       <= mid_in;
      high_ff      <= high_in;
      e_ff         <= e_in;
      es_ff        <= es_in;
      prod_ff      <= prod_in;
      h_ff         <= h_in;
      k_ff         <= k_in;
      r_ff         <= r_in;
      ramp_ff      <= ramp_in;
      y_ff         <= y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_row         = rsp_row_ff;
   assign rsp_col         = rsp_col_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_bad_column  = rsp_bad_ff;

   // a transfer always starts the column check
   a_xfer_to_check: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_CHECK))
      else $error("accepted request did not reach the column check");

   // the row counter never walks past the matrix height while emitting
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (y_ff < cfg_rows))
      else $error("row counter beyond row count");

   // the divider only finishes while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_DIV1) || (state_ff == ST_DIV2)))
      else $error("divider finished outside a wait state");

   // a flagged column is a single dark pixel that closes the column
   a_bad_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_last_ff && (rsp_color_ff == '0)))
      else $error("bad column result malformed");

endmodule

`default_nettype wire
